@@ rtl/lsp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lsp_pkg
// Shared types and constants of the lag severity partition monitor.
// ----------------------------------------------------------------------------
package lsp_pkg;

  localparam int unsigned LevelW = 8;
  localparam int unsigned LenW   = 16;
  localparam int unsigned ScoreW = 17;
  localparam int unsigned SquareW = 2 * ScoreW;
  localparam int unsigned SumW   = 64;
  localparam int unsigned CountW = 32;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] RegPartitionLength = 2'd0;
  localparam logic [1:0] RegLevelOneThresh  = 2'd1;
  localparam logic [1:0] RegLevelTwoThresh  = 2'd2;
  localparam logic [1:0] RegLevelMaximum    = 2'd3;

  // reset values of the registers
  localparam logic [LenW-1:0]   PartitionLengthRst = 16'd64;
  localparam logic [LevelW-1:0] LevelOneThreshRst  = 8'd2;
  localparam logic [LevelW-1:0] LevelTwoThreshRst  = 8'd4;
  localparam logic [LevelW-1:0] LevelMaximumRst    = 8'd8;

  typedef struct packed {
    logic [LenW-1:0]   partition_length;
    logic [LevelW-1:0] level_one_threshold;
    logic [LevelW-1:0] level_two_threshold;
    logic [LevelW-1:0] level_maximum;
  } cfg_t;

  typedef struct packed {
    logic lagged;
    logic restart;
  } in_t;

  typedef struct packed {
    logic [ScoreW-1:0] partition_score;
    logic [SumW-1:0]   square_sum;
    logic [CountW-1:0] partitions_done;
  } out_t;

  // quantum stage to square stage
  typedef struct packed {
    logic              restart;
    logic              close;
    logic [ScoreW-1:0] score;
  } tok_t;

  // square stage to accumulate stage
  typedef struct packed {
    logic               restart;
    logic               close;
    logic [ScoreW-1:0]  score;
    logic [SquareW-1:0] square;
  } sq_tok_t;

endpackage : lsp_pkg
`default_nettype wire

@@ rtl/lsp_cfg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lsp_cfg
// APB-style register file holding partition length, thresholds and ceiling.
// ----------------------------------------------------------------------------
module lsp_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lsp_pkg::AddrW-1:0] paddr,
  input  logic [lsp_pkg::DataW-1:0] pwdata,
  output logic [lsp_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output lsp_pkg::cfg_t             cfg_o
);
  import lsp_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  // update the addressed register on the access cycle
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        RegPartitionLength: cfg_d.partition_length    = pwdata[LenW-1:0];
        RegLevelOneThresh:  cfg_d.level_one_threshold = pwdata[LevelW-1:0];
        RegLevelTwoThresh:  cfg_d.level_two_threshold = pwdata[LevelW-1:0];
        RegLevelMaximum:    cfg_d.level_maximum       = pwdata[LevelW-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.partition_length    <= PartitionLengthRst;
      cfg_q.level_one_threshold <= LevelOneThreshRst;
      cfg_q.level_two_threshold <= LevelTwoThreshRst;
      cfg_q.level_maximum       <= LevelMaximumRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read back the addressed register
  always_comb begin
    case (reg_idx)
      RegPartitionLength: prdata = {{(DataW-LenW){1'b0}}, cfg_q.partition_length};
      RegLevelOneThresh:  prdata = {{(DataW-LevelW){1'b0}}, cfg_q.level_one_threshold};
      RegLevelTwoThresh:  prdata = {{(DataW-LevelW){1'b0}}, cfg_q.level_two_threshold};
      RegLevelMaximum:    prdata = {{(DataW-LevelW){1'b0}}, cfg_q.level_maximum};
      default:            prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule : lsp_cfg
`default_nettype wire

@@ rtl/lsp_quantum.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lsp_quantum
// Per-quantum update of lag level, partition score and position; hands a
// token to the next stage when a partition closes or a restart occurs.
// ----------------------------------------------------------------------------
module lsp_quantum (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lsp_pkg::cfg_t  cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lsp_pkg::in_t   in_data_i,
  output logic           tok_valid_o,
  output lsp_pkg::tok_t  tok_o,
  input  logic           tok_ready_i
);
  import lsp_pkg::*;

  logic [LevelW-1:0] level_q, level_d;
  logic [LenW-1:0]   pos_q, pos_d;
  logic [ScoreW-1:0] score_q, score_d;
  logic              tok_valid_q, tok_valid_d;
  tok_t              tok_q, tok_d;

  logic              accept;
  logic [LevelW-1:0] base_level;
  logic [LenW-1:0]   base_pos;
  logic [ScoreW-1:0] base_score;
  logic [LevelW:0]   raw_level;
  logic [LevelW-1:0] new_level;
  logic [1:0]        points;
  logic [ScoreW-1:0] new_score;
  logic [LenW-1:0]   eff_len;
  logic [LenW:0]     handled;
  logic              close;

  assign in_ready_o = ~tok_valid_q | tok_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  // next level, points and partition position for this quantum
  always_comb begin
    base_level = in_data_i.restart ? '0 : level_q;
    base_pos   = in_data_i.restart ? '0 : pos_q;
    base_score = in_data_i.restart ? '0 : score_q;
    raw_level  = in_data_i.lagged ? ({1'b0, base_level} + {{LevelW{1'b0}}, 1'b1})
                                  : {2'b00, base_level[LevelW-1:1]};
    new_level  = (raw_level > {1'b0, cfg_i.level_maximum}) ? cfg_i.level_maximum
                                                           : raw_level[LevelW-1:0];
    points     = {1'b0, new_level >= cfg_i.level_one_threshold}
               + {1'b0, new_level >= cfg_i.level_two_threshold};
    new_score  = base_score + {{(ScoreW-2){1'b0}}, points};
    eff_len    = (cfg_i.partition_length == '0) ? {{(LenW-1){1'b0}}, 1'b1}
                                                : cfg_i.partition_length;
    handled    = {1'b0, base_pos} + {{LenW{1'b0}}, 1'b1};
    close      = handled >= {1'b0, eff_len};
  end

  // advance the running state on every accepted word
  always_comb begin
    level_d = level_q;
    pos_d   = pos_q;
    score_d = score_q;
    if (accept) begin
      level_d = new_level;
      pos_d   = close ? '0 : handled[LenW-1:0];
      score_d = close ? '0 : new_score;
    end
  end

  // hold a token until the square stage takes it
  always_comb begin
    tok_valid_d = tok_valid_q;
    tok_d       = tok_q;
    if (tok_ready_i) begin
      tok_valid_d = 1'b0;
    end
    if (accept && (close || in_data_i.restart)) begin
      tok_valid_d   = 1'b1;
      tok_d.restart = in_data_i.restart;
      tok_d.close   = close;
      tok_d.score   = new_score;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= '0;
      pos_q       <= '0;
      score_q     <= '0;
      tok_valid_q <= 1'b0;
    end else begin
      level_q     <= level_d;
      pos_q       <= pos_d;
      score_q     <= score_d;
      tok_valid_q <= tok_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  assign tok_valid_o = tok_valid_q;
  assign tok_o       = tok_q;

endmodule : lsp_quantum
`default_nettype wire

@@ rtl/lsp_square.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lsp_square
// Squares the closing partition score in a registered stage.
// ----------------------------------------------------------------------------
module lsp_square (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tok_valid_i,
  input  lsp_pkg::tok_t    tok_i,
  output logic             tok_ready_o,
  output logic             sq_valid_o,
  output lsp_pkg::sq_tok_t sq_o,
  input  logic             sq_ready_i
);
  import lsp_pkg::*;

  logic    sq_valid_q, sq_valid_d;
  sq_tok_t sq_q, sq_d;
  logic    take;

  assign tok_ready_o = ~sq_valid_q | sq_ready_i;
  assign take        = tok_valid_i & tok_ready_o;

  // square the score and hold it for the accumulate stage
  always_comb begin
    sq_valid_d = sq_valid_q;
    sq_d       = sq_q;
    if (sq_ready_i) begin
      sq_valid_d = 1'b0;
    end
    if (take) begin
      sq_valid_d   = 1'b1;
      sq_d.restart = tok_i.restart;
      sq_d.close   = tok_i.close;
      sq_d.score   = tok_i.score;
      sq_d.square  = {{(SquareW-ScoreW){1'b0}}, tok_i.score}
                   * {{(SquareW-ScoreW){1'b0}}, tok_i.score};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q <= 1'b0;
    end else begin
      sq_valid_q <= sq_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q <= sq_d;
  end

  assign sq_valid_o = sq_valid_q;
  assign sq_o       = sq_q;

endmodule : lsp_square
`default_nettype wire

@@ rtl/lsp_accum.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lsp_accum
// Saturating sum of squares, partition count and the output register.
// ----------------------------------------------------------------------------
module lsp_accum (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             sq_valid_i,
  input  lsp_pkg::sq_tok_t sq_i,
  output logic             sq_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output lsp_pkg::out_t    out_data_o
);
  import lsp_pkg::*;

  logic [SumW-1:0]   squares_q, squares_d;
  logic [CountW-1:0] parts_q, parts_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;

  logic              take;
  logic [SumW-1:0]   base_sum;
  logic [CountW-1:0] base_parts;
  logic [SumW:0]     raw_sum;
  logic [SumW-1:0]   new_sum;
  logic [CountW-1:0] new_parts;

  assign sq_ready_o = ~out_valid_q | out_ready_i;
  assign take       = sq_valid_i & sq_ready_o;

  // saturating add of the square, wrapping partition count
  always_comb begin
    base_sum   = sq_i.restart ? '0 : squares_q;
    base_parts = sq_i.restart ? '0 : parts_q;
    raw_sum    = {1'b0, base_sum} + {{(SumW+1-SquareW){1'b0}}, sq_i.square};
    new_sum    = raw_sum[SumW] ? {SumW{1'b1}} : raw_sum[SumW-1:0];
    new_parts  = base_parts + {{(CountW-1){1'b0}}, 1'b1};
  end

  // update totals, load the output word on a closing partition
  always_comb begin
    squares_d   = squares_q;
    parts_d     = parts_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (take) begin
      squares_d = base_sum;
      parts_d   = base_parts;
      if (sq_i.close) begin
        squares_d             = new_sum;
        parts_d               = new_parts;
        out_valid_d           = 1'b1;
        out_d.partition_score = sq_i.score;
        out_d.square_sum      = new_sum;
        out_d.partitions_done = new_parts;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      squares_q   <= '0;
      parts_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      squares_q   <= squares_d;
      parts_q     <= parts_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule : lsp_accum
`default_nettype wire

@@ rtl/lag_severity_partition_monitor_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lag_severity_partition_monitor_top
// Lag severity partition monitor: level tracking, partition scoring and a
// saturating sum of squared scores behind valid/ready channels.
// ----------------------------------------------------------------------------
// One lag word is taken every clock cycle as long as the output side keeps
// up. Each word updates the recent-lag level and partition score at once.
// A word that closes a partition passes a quantum stage, a squaring stage
// (17x17 multiplier) and an accumulate stage (64-bit saturating add). Each
// stage is one register: the token, square and output registers, in turn.
// Words that do not close a partition produce no result. Each stage holds
// its word while the next one is stalled, so input is refused only once
// every stage is full. The user must write registers over the APB port
// only while no word is in flight; the block itself does not enforce this.
module lag_severity_partition_monitor_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lsp_pkg::AddrW-1:0] paddr,
  input  logic [lsp_pkg::DataW-1:0] pwdata,
  output logic [lsp_pkg::DataW-1:0] prdata,
  output logic                      pready,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  lsp_pkg::in_t              in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output lsp_pkg::out_t             out_data_o
);
  import lsp_pkg::*;

  cfg_t    cfg;
  logic    tok_valid;
  tok_t    tok;
  logic    tok_ready;
  logic    sq_valid;
  sq_tok_t sq_tok;
  logic    sq_ready;

  lsp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lsp_quantum u_quantum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .tok_valid_o (tok_valid),
    .tok_o       (tok),
    .tok_ready_i (tok_ready)
  );

  lsp_square u_square (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_valid),
    .tok_i       (tok),
    .tok_ready_o (tok_ready),
    .sq_valid_o  (sq_valid),
    .sq_o        (sq_tok),
    .sq_ready_i  (sq_ready)
  );

  lsp_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sq_valid_i  (sq_valid),
    .sq_i        (sq_tok),
    .sq_ready_o  (sq_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  // the sum always covers the square of the score it is reported with
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.square_sum >=
      ({{(SumW-ScoreW){1'b0}}, out_data_o.partition_score}
       * {{(SumW-ScoreW){1'b0}}, out_data_o.partition_score})))
    else $error("square_sum below the square of partition_score");

  // a stalled quantum token holds until the square stage takes it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_valid && !tok_ready) |=> (tok_valid && $stable(tok)))
    else $error("quantum token lost or changed while stalled");

  // input is refused only while the token and square stages are both occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (tok_valid && sq_valid))
    else $error("input refused with room in the pipeline");
`endif

endmodule : lag_severity_partition_monitor_top
`default_nettype wire

@@ sim/lag_severity_partition_monitor_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lag_severity_partition_monitor_top_test
// Self-checking bench of the lag severity partition monitor. A table of
// directed quanta and register writes runs first, then random phases of lag
// bursts under changing register settings. Every accepted quantum is scored
// by a local copy of the level and partition logic, and each result word is
// checked against the oldest expected one. Both channels idle at random,
// except in one steady phase.
// ----------------------------------------------------------------------------
module lag_severity_partition_monitor_top_test;

  typedef enum logic {RowQuantum, RowRegister} row_kind_e;

  typedef struct packed {
    row_kind_e      kind;
    logic [1:0]     reg_idx;
    logic [15:0]    value;
    lsp_pkg::in_t   word;
    logic           known;
    logic           closes;
    lsp_pkg::out_t  result;
  } plan_row_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [lsp_pkg::AddrW-1:0] paddr = '0;
  logic [lsp_pkg::DataW-1:0] pwdata = '0;
  logic [lsp_pkg::DataW-1:0] prdata;
  logic                      pready;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  lsp_pkg::in_t              in_data = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  lsp_pkg::out_t             out_data;

  // local copy of the registers and the running state
  lsp_pkg::cfg_t shadow_cfg;
  logic [7:0]    lag_level;
  logic [15:0]   quanta_seen;
  logic [16:0]   open_score;
  logic [63:0]   square_acc;
  logic [31:0]   closed_count;

  lsp_pkg::out_t pending_results[$];
  int            fail_count = 0;
  bit            steady = 1'b0;

  lag_severity_partition_monitor_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Score one quantum; return 1 with the result when it closes a partition.
  function automatic bit score_quantum(input lsp_pkg::in_t w, output lsp_pkg::out_t r);
    logic [8:0]  lvl;
    logic [15:0] len;
    logic [16:0] handled;
    logic [33:0] sq;
    logic [64:0] sum;
    r = '0;
    if (w.restart) begin
      lag_level    = '0;
      quanta_seen  = '0;
      open_score   = '0;
      square_acc   = '0;
      closed_count = '0;
    end
    // halve on a quiet quantum, bump on a lag, then clamp to the ceiling
    lvl = w.lagged ? {1'b0, lag_level} + 9'd1 : {2'b00, lag_level[7:1]};
    if (lvl > {1'b0, shadow_cfg.level_maximum}) lvl = {1'b0, shadow_cfg.level_maximum};
    lag_level = lvl[7:0];
    if (lvl >= {1'b0, shadow_cfg.level_one_threshold}) open_score = open_score + 17'd1;
    if (lvl >= {1'b0, shadow_cfg.level_two_threshold}) open_score = open_score + 17'd1;
    len = (shadow_cfg.partition_length == '0) ? 16'd1 : shadow_cfg.partition_length;
    handled = {1'b0, quanta_seen} + 17'd1;
    if (handled < {1'b0, len}) begin
      quanta_seen = handled[15:0];
      return 1'b0;
    end
    // close the partition: saturating sum of squares, wrapping count
    sq = open_score * open_score;
    sum = {1'b0, square_acc} + {31'b0, sq};
    square_acc = sum[64] ? '1 : sum[63:0];
    closed_count = closed_count + 32'd1;
    r.partition_score = open_score;
    r.square_sum      = square_acc;
    r.partitions_done = closed_count;
    open_score  = '0;
    quanta_seen = '0;
    return 1'b1;
  endfunction

  // Offer one quantum word, score it on acceptance, then maybe idle.
  task automatic send_quantum(input lsp_pkg::in_t w, input bit known, input bit known_closes,
                              input lsp_pkg::out_t known_result);
    lsp_pkg::out_t r;
    bit            closes;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk_i); while (!in_ready);
    closes = score_quantum(w, r);
    if (known) begin
      closes = known_closes;
      r      = known_result;
    end
    if (closes) pending_results.insert(pending_results.size(), r);
    if (!steady && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // Drop valid, wait for every expected word, then let the pipeline empty.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  // Write one register with junk in the unused bits, then read it back.
  task automatic write_register(input logic [1:0] idx, input logic [15:0] field);
    logic [31:0] data;
    logic [31:0] stored;
    data = $urandom;
    stored = '0;
    case (idx)
      lsp_pkg::RegPartitionLength: begin
        data[15:0] = field;
        stored = {16'b0, field};
        shadow_cfg.partition_length = field;
      end
      lsp_pkg::RegLevelOneThresh: begin
        data[7:0] = field[7:0];
        stored = {24'b0, field[7:0]};
        shadow_cfg.level_one_threshold = field[7:0];
      end
      lsp_pkg::RegLevelTwoThresh: begin
        data[7:0] = field[7:0];
        stored = {24'b0, field[7:0]};
        shadow_cfg.level_two_threshold = field[7:0];
      end
      default: begin
        data[7:0] = field[7:0];
        stored = {24'b0, field[7:0]};
        shadow_cfg.level_maximum = field[7:0];
      end
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== stored) begin
      $error("register %0d: expected %0d, actual %0d", idx, stored, prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic plan_row_t reg_row(input logic [1:0] idx, input logic [15:0] v);
    plan_row_t row;
    row = '0;
    row.kind    = RowRegister;
    row.reg_idx = idx;
    row.value   = v;
    return row;
  endfunction

  function automatic plan_row_t quantum_row(input bit lag, input bit rst);
    plan_row_t row;
    row = '0;
    row.kind         = RowQuantum;
    row.word.lagged  = lag;
    row.word.restart = rst;
    return row;
  endfunction

  function automatic plan_row_t known_row(input bit lag, input bit rst, input logic [16:0] s,
                                          input logic [63:0] sq, input logic [31:0] n);
    plan_row_t row;
    row = quantum_row(lag, rst);
    row.known  = 1'b1;
    row.closes = 1'b1;
    row.result.partition_score = s;
    row.result.square_sum      = sq;
    row.result.partitions_done = n;
    return row;
  endfunction

  // Stall the result side at random.
  always @(posedge clk_i) begin
    out_ready <= steady || ($urandom_range(99) >= 15);
  end

  // Check each result word against the oldest expected one.
  always @(posedge clk_i) begin
    lsp_pkg::out_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: partition_score %0d", out_data.partition_score);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.partition_score !== want.partition_score) begin
          $error("partition_score: expected %0d, actual %0d",
                 want.partition_score, out_data.partition_score);
          fail_count++;
        end
        if (out_data.square_sum !== want.square_sum) begin
          $error("square_sum: expected %0d, actual %0d", want.square_sum, out_data.square_sum);
          fail_count++;
        end
        if (out_data.partitions_done !== want.partitions_done) begin
          $error("partitions_done: expected %0d, actual %0d",
                 want.partitions_done, out_data.partitions_done);
          fail_count++;
        end
      end
    end
  end

  initial begin
    plan_row_t    plan[$];
    lsp_pkg::in_t w;
    int           n_items;
    int           run_left;
    int           run_hi;
    bit           run_lag;
    bit           clean;

    shadow_cfg.partition_length    = lsp_pkg::PartitionLengthRst;
    shadow_cfg.level_one_threshold = lsp_pkg::LevelOneThreshRst;
    shadow_cfg.level_two_threshold = lsp_pkg::LevelTwoThreshRst;
    shadow_cfg.level_maximum       = lsp_pkg::LevelMaximumRst;
    lag_level    = '0;
    quanta_seen  = '0;
    open_score   = '0;
    square_acc   = '0;
    closed_count = '0;
    run_left = 0;
    run_lag  = 1'b0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one-quantum partitions with the reset thresholds
    plan.insert(plan.size(), reg_row(lsp_pkg::RegPartitionLength, 16'd1));
    plan.insert(plan.size(), known_row(1'b0, 1'b1, 17'd0, 64'd0, 32'd1));
    plan.insert(plan.size(), known_row(1'b1, 1'b0, 17'd0, 64'd0, 32'd2));
    plan.insert(plan.size(), known_row(1'b1, 1'b0, 17'd1, 64'd1, 32'd3));
    plan.insert(plan.size(), known_row(1'b1, 1'b0, 17'd1, 64'd2, 32'd4));
    plan.insert(plan.size(), known_row(1'b1, 1'b0, 17'd2, 64'd6, 32'd5));
    plan.insert(plan.size(), known_row(1'b0, 1'b0, 17'd1, 64'd7, 32'd6));
    plan.insert(plan.size(), known_row(1'b1, 1'b1, 17'd0, 64'd0, 32'd1));
    // zero ceiling and zero thresholds: every quantum earns two points
    plan.insert(plan.size(), reg_row(lsp_pkg::RegLevelMaximum, 16'd0));
    plan.insert(plan.size(), reg_row(lsp_pkg::RegLevelOneThresh, 16'd0));
    plan.insert(plan.size(), reg_row(lsp_pkg::RegLevelTwoThresh, 16'd0));
    plan.insert(plan.size(), known_row(1'b1, 1'b0, 17'd2, 64'd4, 32'd2));
    // zero partition length acts as one
    plan.insert(plan.size(), reg_row(lsp_pkg::RegPartitionLength, 16'd0));
    plan.insert(plan.size(), known_row(1'b0, 1'b0, 17'd2, 64'd8, 32'd3));
    // top thresholds and ceiling: no points
    plan.insert(plan.size(), reg_row(lsp_pkg::RegLevelOneThresh, 16'd255));
    plan.insert(plan.size(), reg_row(lsp_pkg::RegLevelTwoThresh, 16'd255));
    plan.insert(plan.size(), reg_row(lsp_pkg::RegLevelMaximum, 16'd255));
    plan.insert(plan.size(), reg_row(lsp_pkg::RegPartitionLength, 16'd4));
    plan.insert(plan.size(), quantum_row(1'b1, 1'b1));
    plan.insert(plan.size(), quantum_row(1'b1, 1'b0));
    plan.insert(plan.size(), quantum_row(1'b1, 1'b0));
    plan.insert(plan.size(), known_row(1'b1, 1'b0, 17'd0, 64'd0, 32'd1));
    // shorten the length under an open partition
    plan.insert(plan.size(), reg_row(lsp_pkg::RegLevelOneThresh, 16'd1));
    plan.insert(plan.size(), reg_row(lsp_pkg::RegLevelTwoThresh, 16'd3));
    plan.insert(plan.size(), reg_row(lsp_pkg::RegLevelMaximum, 16'd8));
    plan.insert(plan.size(), reg_row(lsp_pkg::RegPartitionLength, 16'd10));
    repeat (5) plan.insert(plan.size(), quantum_row(1'b1, 1'b0));
    plan.insert(plan.size(), reg_row(lsp_pkg::RegPartitionLength, 16'd3));
    plan.insert(plan.size(), quantum_row(1'b0, 1'b0));
    plan.insert(plan.size(), quantum_row(1'b1, 1'b0));
    plan.insert(plan.size(), quantum_row(1'b1, 1'b0));
    // lower the ceiling under a high level, also on a quiet quantum
    plan.insert(plan.size(), reg_row(lsp_pkg::RegLevelMaximum, 16'd1));
    plan.insert(plan.size(), quantum_row(1'b0, 1'b0));
    plan.insert(plan.size(), quantum_row(1'b1, 1'b0));
    plan.insert(plan.size(), quantum_row(1'b0, 1'b1));

    foreach (plan[k]) begin
      if (plan[k].kind == RowRegister) begin
        settle();
        write_register(plan[k].reg_idx, plan[k].value);
      end else begin
        send_quantum(plan[k].word, plan[k].known, plan[k].closes, plan[k].result);
      end
    end

    // random phases of lag bursts under fresh settings
    for (int p = 0; p < 10; p++) begin
      settle();
      clean   = (p == 0);
      steady  = (p == 4);
      n_items = clean ? 300 : 172;
      if (clean) begin
        // drive the level to the top ceiling
        write_register(lsp_pkg::RegPartitionLength, 16'd1);
        write_register(lsp_pkg::RegLevelOneThresh, 16'($urandom_range(0, 3)));
        write_register(lsp_pkg::RegLevelTwoThresh, 16'd255);
        write_register(lsp_pkg::RegLevelMaximum, 16'd255);
        run_hi = 300;
      end else begin
        if ($urandom_range(3) == 0)
          write_register(lsp_pkg::RegPartitionLength, 16'($urandom_range(0, 2)));
        else if ($urandom_range(7) == 0)
          write_register(lsp_pkg::RegPartitionLength, 16'($urandom_range(50, 300)));
        else
          write_register(lsp_pkg::RegPartitionLength, 16'($urandom_range(3, 24)));
        if ($urandom_range(7) == 0) begin
          write_register(lsp_pkg::RegLevelOneThresh, 16'($urandom_range(0, 255)));
          write_register(lsp_pkg::RegLevelTwoThresh, 16'($urandom_range(0, 255)));
        end else begin
          write_register(lsp_pkg::RegLevelOneThresh, 16'($urandom_range(0, 10)));
          write_register(lsp_pkg::RegLevelTwoThresh, 16'($urandom_range(0, 10)));
        end
        if ($urandom_range(7) == 0)
          write_register(lsp_pkg::RegLevelMaximum, 16'($urandom_range(0, 255)));
        else
          write_register(lsp_pkg::RegLevelMaximum, 16'($urandom_range(0, 12)));
        run_hi = $urandom_range(2, 40);
      end
      run_left = 0;
      for (int i = 0; i < n_items; i++) begin
        // pause halfway, then move the partition length
        if (!clean && i == n_items / 2 && $urandom_range(1) == 1) begin
          settle();
          write_register(lsp_pkg::RegPartitionLength, 16'($urandom_range(1, 6)));
        end
        if (run_left == 0) begin
          run_lag = !run_lag;
          if (clean && run_lag) run_left = $urandom_range(200, 300);
          else run_left = $urandom_range(1, run_lag ? run_hi : 6);
        end
        run_left--;
        w.lagged  = (!clean && $urandom_range(9) == 0) ? 1'($urandom_range(1)) : run_lag;
        w.restart = !clean && ($urandom_range(59) == 0);
        send_quantum(w, 1'b0, 1'b0, '0);
      end
      steady = 1'b0;
    end

    settle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
